// ===== rtl/core/png_scanline_unfilter_unit_assert.svh =====
// Assertion macros shared by the scanline unfilter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PNG_SCANLINE_UNFILTER_UNIT_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define PNGU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PNGU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pngu_pkg.sv =====
// Shared types and constants of the PNG scanline unfilter unit.
// No dependencies; used by front, back and top level.
`default_nettype none

package pngu_pkg;

    localparam int COL_W      = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_PIXEL = 1'b1;

    localparam logic [2:0] FILT_NONE    = 3'd0;
    localparam logic [2:0] FILT_SUB     = 3'd1;
    localparam logic [2:0] FILT_UP      = 3'd2;
    localparam logic [2:0] FILT_AVG     = 3'd3;
    localparam logic [2:0] FILT_PAETH   = 3'd4;
    localparam logic [2:0] FILT_INVALID = 3'd5;

    typedef struct packed {
        logic [2:0] filter;
        logic       first_row;
        logic       row_first;
        logic       last;
        logic       too_long;
        logic       marker;
        logic       ac_valid;
        logic [2:0] step_m1;
    } item_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/pngu_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module pngu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pngu_front.sv =====
// Front end: config registers, row size, column tracking and byte classification.
// Depends on pngu_pkg and the assertion macro header.
`default_nettype none

`include "png_scanline_unfilter_unit_assert.svh"

module pngu_front #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [pngu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pngu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [7:0]                         s_stream_byte,
    input  wire logic                               s_image_start,
    input  wire logic                               q_full,
    output logic                                    push,
    output pngu_pkg::item_ctrl_t                    push_ctrl,
    output logic [7:0]                              push_byte,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]        push_idx
);

    localparam int ColW = pngu_pkg::COL_W;
    localparam int IdxW = $clog2(MAX_ROW_BYTES);

    logic [15:0]     width_reg, width_next;
    logic [6:0]      bpp_reg, bpp_next;
    logic [ColW-1:0] rb_reg, rb_next;
    logic [2:0]      step_m1_reg, step_m1_next;
    logic            long_reg, long_next;

    logic [ColW-1:0] column_reg, column_next;
    logic            first_row_reg, first_row_next;
    logic [2:0]      filter_reg, filter_next;

    logic [15:0]     w_eff;
    logic [6:0]      b_eff;
    logic [8:0]      tail_bits;
    logic [3:0]      step_raw;
    logic [3:0]      step_cap;

    logic            s_fire;
    logic [ColW-1:0] col_eff;
    logic [ColW-1:0] idx;
    logic            fr_eff;
    logic            is_filter;
    logic            last;
    logic            beyond;

    // config write and derived row geometry
    always_comb begin
        width_next = width_reg;
        bpp_next   = bpp_reg;
        if (cfg_wr_en && cfg_index == pngu_pkg::REG_IMAGE_WIDTH) begin
            width_next = cfg_wdata;
        end
        if (cfg_wr_en && cfg_index == pngu_pkg::REG_BITS_PER_PIXEL) begin
            bpp_next = cfg_wdata[6:0];
        end
        w_eff = (width_next == 16'd0) ? 16'd1 : width_next;
        if (bpp_next == 7'd0) begin
            b_eff = 7'd1;
        end else if (bpp_next > 7'd64) begin
            b_eff = 7'd64;
        end else begin
            b_eff = bpp_next;
        end
        tail_bits = 9'(w_eff[2:0]) * 9'(b_eff) + 9'd7;
        rb_next   = ColW'(ColW'(w_eff[15:3]) * ColW'(b_eff)) + ColW'(tail_bits[8:3]);
        long_next = rb_next > ColW'(MAX_ROW_BYTES);
        step_raw  = 4'((5'(b_eff[6:0] > 7'd0 ? b_eff[6:3] : 4'd0)
                    + 5'(b_eff[2:0] != 3'd0)));
        step_cap  = (step_raw > 4'(MAX_PIXEL_BYTES)) ? 4'(MAX_PIXEL_BYTES) : step_raw;
        step_m1_next = 3'(step_cap - 4'd1);
    end

    // classification of the beat
    assign s_ready   = !q_full;
    assign s_fire    = s_valid && s_ready;
    assign col_eff   = s_image_start ? '0 : column_reg;
    assign fr_eff    = s_image_start || first_row_reg;
    assign is_filter = (col_eff == '0);
    assign idx       = col_eff - ColW'(1);
    assign last      = col_eff >= rb_reg;
    assign beyond    = idx >= ColW'(MAX_ROW_BYTES);

    assign push      = s_fire && !is_filter && (!beyond || last);
    assign push_byte = s_stream_byte;
    assign push_idx  = idx[IdxW-1:0];

    always_comb begin
        push_ctrl           = '0;
        push_ctrl.filter    = filter_reg;
        push_ctrl.first_row = fr_eff;
        push_ctrl.row_first = (col_eff == ColW'(1));
        push_ctrl.last      = last;
        push_ctrl.too_long  = long_reg;
        push_ctrl.marker    = beyond;
        push_ctrl.ac_valid  = col_eff > (ColW'(step_m1_reg) + ColW'(1));
        push_ctrl.step_m1   = step_m1_reg;
    end

    always_comb begin
        column_next    = column_reg;
        first_row_next = first_row_reg;
        filter_next    = filter_reg;
        if (s_fire) begin
            first_row_next = fr_eff;
            if (is_filter) begin
                filter_next = (s_stream_byte > 8'd4) ? pngu_pkg::FILT_INVALID
                                                     : s_stream_byte[2:0];
                column_next = ColW'(1);
            end else if (last) begin
                column_next    = '0;
                first_row_next = 1'b0;
            end else begin
                column_next = col_eff + ColW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= 16'd1;
            bpp_reg       <= 7'd8;
            rb_reg        <= ColW'(1);
            step_m1_reg   <= 3'd0;
            long_reg      <= 1'b0;
            column_reg    <= '0;
            first_row_reg <= 1'b1;
            filter_reg    <= pngu_pkg::FILT_NONE;
        end else begin
            width_reg     <= width_next;
            bpp_reg       <= bpp_next;
            rb_reg        <= rb_next;
            step_m1_reg   <= step_m1_next;
            long_reg      <= long_next;
            column_reg    <= column_next;
            first_row_reg <= first_row_next;
            filter_reg    <= filter_next;
        end
    end

    `PNGU_ASSERT_NXT(a_row_end_clears_first, aclk, aresetn, push && push_ctrl.last, !first_row_reg, "first_row still set after row end")
    `PNGU_ASSERT_NOW(a_data_in_buffer, aclk, aresetn, push && !push_ctrl.marker, idx < ColW'(MAX_ROW_BYTES), "data beat beyond line buffer")

endmodule

`default_nettype wire

// ===== rtl/core/pngu_queue.sv =====
// Short FIFO of classified beats between front and back.
// Depends on the assertion macro header.
`default_nettype none

`include "png_scanline_unfilter_unit_assert.svh"

module pngu_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  not_empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CntW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + CntW'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PNGU_ASSERT_NOW(a_no_push_full, aclk, aresetn, wr_en, !full || rd_en, "push into full queue")
    `PNGU_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, rd_en, not_empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== rtl/core/pngu_back.sv =====
// Back end: prior-row buffer, filter reconstruction and result register.
// Depends on pngu_pkg, pngu_ram and the assertion macro header.
`default_nettype none

`include "png_scanline_unfilter_unit_assert.svh"

module pngu_back #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               q_valid,
    input  wire pngu_pkg::item_ctrl_t               q_ctrl,
    input  wire logic [7:0]                         q_byte,
    input  wire logic [$clog2(MAX_ROW_BYTES)-1:0]   q_idx,
    output logic                                    q_pop,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [7:0]                              m_pixel_byte,
    output logic                                    m_row_end,
    output logic                                    m_bad_filter,
    output logic                                    m_row_too_long
);

    localparam int IdxW = $clog2(MAX_ROW_BYTES);
    localparam int HwW  = $clog2(MAX_ROW_BYTES + 1);
    localparam int SelW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0] sa, sb, sc, pa, pb, pc;
        sa = signed'({2'b00, a});
        sb = signed'({2'b00, b});
        sc = signed'({2'b00, c});
        pa = sb - sc;
        pb = sa - sc;
        pc = sa + sb - sc - sc;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

    pngu_pkg::item_ctrl_t s2_ctrl_reg;
    logic                 s2_valid_reg;
    logic [7:0]           s2_byte_reg;
    logic [IdxW-1:0]      s2_idx_reg;
    logic                 s2_fwd_reg;
    logic                 s2_zero_reg;
    logic [7:0]           fwd_data_reg;
    logic [HwW-1:0]       hw_reg;
    logic [7:0]           left_win_reg [MAX_PIXEL_BYTES];
    logic [7:0]           up_win_reg   [MAX_PIXEL_BYTES];

    logic                 m_valid_reg;
    logic [7:0]           m_pixel_reg;
    logic                 m_row_end_reg;
    logic                 m_bad_reg;
    logic                 m_long_reg;

    logic                 out_free;
    logic                 s2_fire;
    logic                 s2_write;
    logic                 fwd_hit;
    logic [7:0]           ram_rdata;
    logic [7:0]           a_val, b_val, c_val;
    logic [8:0]           avg_sum;
    logic [7:0]           x_val;
    logic [SelW-1:0]      sel;

    assign out_free = !m_valid_reg || m_ready;
    assign s2_fire  = s2_valid_reg && out_free;
    assign s2_write = s2_fire && !s2_ctrl_reg.marker;
    assign q_pop    = q_valid && (!s2_valid_reg || s2_fire);
    assign fwd_hit  = s2_write && (s2_idx_reg == q_idx);

    pngu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_prior_row (
        .aclk    (aclk),
        .wr_en   (s2_write),
        .wr_addr (s2_idx_reg),
        .wr_data (x_val),
        .rd_en   (q_pop),
        .rd_addr (q_idx),
        .rd_data (ram_rdata)
    );

    always_comb begin
        sel     = s2_ctrl_reg.step_m1[SelW-1:0];
        b_val   = s2_zero_reg ? 8'd0 : (s2_fwd_reg ? fwd_data_reg : ram_rdata);
        a_val   = s2_ctrl_reg.ac_valid ? left_win_reg[sel] : 8'd0;
        c_val   = s2_ctrl_reg.ac_valid ? up_win_reg[sel] : 8'd0;
        avg_sum = 9'(a_val) + 9'(b_val);
        unique case (s2_ctrl_reg.filter)
            pngu_pkg::FILT_SUB:   x_val = s2_byte_reg + a_val;
            pngu_pkg::FILT_UP:    x_val = s2_byte_reg + b_val;
            pngu_pkg::FILT_AVG:   x_val = s2_byte_reg + avg_sum[8:1];
            pngu_pkg::FILT_PAETH: x_val = s2_byte_reg + paeth_pred(a_val, b_val, c_val);
            default:              x_val = s2_byte_reg;
        endcase
    end

    // stage 2 payload, forward, windows and output payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s2_ctrl_reg  <= q_ctrl;
            s2_byte_reg  <= q_byte;
            s2_idx_reg   <= q_idx;
            s2_fwd_reg   <= fwd_hit;
            s2_zero_reg  <= q_ctrl.first_row || (!fwd_hit && (HwW'(q_idx) >= hw_reg));
            fwd_data_reg <= x_val;
        end
        if (s2_write) begin
            for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
                left_win_reg[k] <= s2_ctrl_reg.row_first ? 8'd0 : left_win_reg[k-1];
                up_win_reg[k]   <= s2_ctrl_reg.row_first ? 8'd0 : up_win_reg[k-1];
            end
            left_win_reg[0] <= x_val;
            up_win_reg[0]   <= b_val;
        end
        if (s2_fire) begin
            m_pixel_reg   <= s2_ctrl_reg.marker ? 8'd0 : x_val;
            m_row_end_reg <= s2_ctrl_reg.last;
            m_bad_reg     <= (s2_ctrl_reg.filter == pngu_pkg::FILT_INVALID);
            m_long_reg    <= s2_ctrl_reg.marker || s2_ctrl_reg.too_long;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            hw_reg       <= '0;
        end else begin
            if (q_pop) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_fire) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s2_write && (HwW'(s2_idx_reg) + HwW'(1) > hw_reg)) begin
                hw_reg <= HwW'(s2_idx_reg) + HwW'(1);
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_byte   = m_pixel_reg;
    assign m_row_end      = m_row_end_reg;
    assign m_bad_filter   = m_bad_reg;
    assign m_row_too_long = m_long_reg;

    `PNGU_ASSERT_NXT(a_s2_holds, aclk, aresetn, s2_valid_reg && !s2_fire, s2_valid_reg && $stable(s2_idx_reg), "stalled stage 2 beat changed")
    `PNGU_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, hw_reg <= HwW'(MAX_ROW_BYTES), "fill mark beyond line buffer")

endmodule

`default_nettype wire

// ===== rtl/core/png_scanline_unfilter_unit.sv =====
// PNG scanline unfilter: one inflated byte per beat in, one reconstructed byte per beat out.
// Path: an accepted byte goes through the queue, stage 2 and the output register to result valid.
// Throughput: one byte per cycle unless m_ready stalls; Sub/Avg/Paeth close a loop in stage 2.
// Filter bytes give no result; bytes beyond the line buffer give none, but a row's last one gives 0, flagged too long.
// Reset: width 1, 8 bits per pixel; prior row reads as zero via a fill mark, no clearing pass.
// Depends on pngu_pkg, pngu_front, pngu_queue, pngu_back and pngu_ram.
`default_nettype none

module png_scanline_unfilter_unit #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [pngu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pngu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [7:0]                         s_stream_byte,
    input  wire logic                               s_image_start,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [7:0]                              m_pixel_byte,
    output logic                                    m_row_end,
    output logic                                    m_bad_filter,
    output logic                                    m_row_too_long
);

    localparam int IdxW  = $clog2(MAX_ROW_BYTES);
    localparam int CtrlW = $bits(pngu_pkg::item_ctrl_t);
    localparam int QW    = CtrlW + 8 + IdxW;

    logic                 push;
    pngu_pkg::item_ctrl_t push_ctrl;
    logic [7:0]           push_byte;
    logic [IdxW-1:0]      push_idx;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [QW-1:0]        q_data;
    pngu_pkg::item_ctrl_t q_ctrl;

    pngu_front #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .s_image_start (s_image_start),
        .q_full        (q_full),
        .push          (push),
        .push_ctrl     (push_ctrl),
        .push_byte     (push_byte),
        .push_idx      (push_idx)
    );

    pngu_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (push),
        .wr_data   ({push_ctrl, push_byte, push_idx}),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_data),
        .not_empty (q_valid)
    );

    assign q_ctrl = pngu_pkg::item_ctrl_t'(q_data[QW-1 -: CtrlW]);

    pngu_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ctrl         (q_ctrl),
        .q_byte         (q_data[IdxW +: 8]),
        .q_idx          (q_data[IdxW-1:0]),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_byte   (m_pixel_byte),
        .m_row_end      (m_row_end),
        .m_bad_filter   (m_bad_filter),
        .m_row_too_long (m_row_too_long)
    );

endmodule

`default_nettype wire
